// File: src/tmsp_pkg.sv
// Shared types and constants for the tile-map stream parser.
`default_nettype none

package tmsp_pkg;

    localparam int SIDE_W      = 9;
    localparam int DATA_W      = 8;
    localparam int VALUE_W     = 32;
    localparam int CFG_INDEX_W = 8;
    localparam int TOTAL_W     = 17;
    localparam int POS_W       = 17;
    localparam int LAST_W      = 16;
    localparam int HEADER_W    = 32;
    localparam int COORD_W     = 8;
    localparam int PIXEL_W     = 16;
    localparam int NIBBLE_W    = 4;
    localparam int INDEX_W     = 16;

    localparam int HEADER_BYTES = 8;
    localparam int PIX_MAX      = 256;

    localparam logic [POS_W-1:0] POS_LEVEL_END  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_START_END  = POS_W'(5);
    localparam logic [POS_W-1:0] POS_FINISH_END = POS_W'(7);

    localparam logic [NIBBLE_W-1:0] SOLID_CODE = NIBBLE_W'(1);

    localparam logic [SIDE_W-1:0] MAP_WIDTH_RESET  = SIDE_W'(32);
    localparam logic [SIDE_W-1:0] MAP_HEIGHT_RESET = SIDE_W'(32);
    localparam logic [SIDE_W-1:0] PIX_WIDTH_RESET  = SIDE_W'(16);
    localparam logic [SIDE_W-1:0] PIX_HEIGHT_RESET = SIDE_W'(16);

    typedef enum logic [2:0] {
        KIND_LEVEL  = 3'd0,
        KIND_START  = 3'd1,
        KIND_FINISH = 3'd2,
        KIND_TILE   = 3'd3,
        KIND_ERROR  = 3'd4
    } record_kind_t;

    typedef enum logic [1:0] {
        FAULT_NONE   = 2'd0,
        FAULT_LENGTH = 2'd1,
        FAULT_INDEX  = 2'd2
    } fault_code_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAP_WIDTH   = 8'd0,
        REG_MAP_HEIGHT  = 8'd1,
        REG_PIX_WIDTH   = 8'd2,
        REG_PIX_HEIGHT  = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [SIDE_W-1:0]  width;
        logic [SIDE_W-1:0]  pix_w;
        logic [SIDE_W-1:0]  pix_h;
        logic [TOTAL_W-1:0] total;
        logic [LAST_W-1:0]  last;
    } map_geom_t;

    typedef struct packed {
        record_kind_t         kind;
        logic [VALUE_W-1:0]   value;
        fault_code_t          fault;
        logic [COORD_W-1:0]   column;
        logic [COORD_W-1:0]   row;
        logic [PIXEL_W-1:0]   px;
        logic [PIXEL_W-1:0]   py;
        logic                 solid;
        logic                 run_last;
    } record_t;

endpackage

`default_nettype wire

// File: src/tmsp_byte_if.sv
// Input byte channel of the tile-map stream parser.
`default_nettype none

interface tmsp_byte_if
    import tmsp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

// File: src/tmsp_rec_if.sv
// Result record channel of the tile-map stream parser.
`default_nettype none

interface tmsp_rec_if
    import tmsp_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [2:0]                record_kind;
    logic signed [VALUE_W-1:0] record_value;
    logic [1:0]                fault_code;
    logic [COORD_W-1:0]        tile_column;
    logic [COORD_W-1:0]        tile_row;
    logic [PIXEL_W-1:0]        pixel_x;
    logic [PIXEL_W-1:0]        pixel_y;
    logic                      is_solid;
    logic                      run_last;

    modport source (output valid, output record_kind, output record_value, output fault_code,
                    output tile_column, output tile_row, output pixel_x, output pixel_y,
                    output is_solid, output run_last, input ready);
    modport sink   (input valid, input record_kind, input record_value, input fault_code,
                    input tile_column, input tile_row, input pixel_x, input pixel_y,
                    input is_solid, input run_last, output ready);
endinterface

`default_nettype wire

// File: src/tmsp_cfg_if.sv
// Configuration write channel of the tile-map stream parser.
`default_nettype none

interface tmsp_cfg_if
    import tmsp_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [SIDE_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/tile_map_stream_parser.sv
// Tile-map stream parser top level.
//
// Channels: bytes (sink) takes one file byte per request with an end_of_file mark;
// records (source) gives level number, start/finish index, tile and error records;
// cfg (sink) writes map_width, map_height, cell_pixel_width, cell_pixel_height
// by index 0..3, always ready; other indexes are ignored.
// Path: an accepted byte waits in the byte register; its records pass the record register.
// Throughput: a tile byte with two tiles gives both through the single record register,
// one per cycle while the receiver does not stall. Bytes that give no record (header
// bytes before a field end, pad nibble, bytes while faulted) also wait for a free
// record register. The byte register refills in the cycle it is consumed.
// Reset: all parser state clears and the registers take 32, 32, 16, 16.
// Receiver stall: the record register holds; the core waits, and at most one more
// byte is taken into the byte register before bytes.ready drops.
// Register writes must happen while no byte is in flight.
`default_nettype none

module tile_map_stream_parser
    import tmsp_pkg::*;
#(
    parameter int MAX_MAP_SIDE = 256
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    tmsp_byte_if.sink   bytes,
    tmsp_rec_if.source  records,
    tmsp_cfg_if.sink    cfg
);

    map_geom_t geom;
    logic      out_free;
    logic      res_valid;
    record_t   res;

    tmsp_cfg_regs #(
        .MAX_MAP_SIDE (MAX_MAP_SIDE)
    ) u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .geom  (geom)
    );

    tmsp_parse_core u_parse_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (bytes),
        .geom      (geom),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    tmsp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .records   (records)
    );

endmodule

`default_nettype wire

// File: src/tmsp_cfg_regs.sv
// Configuration registers and registered map geometry (clamped sides, tile count, last byte).
`default_nettype none

module tmsp_cfg_regs
    import tmsp_pkg::*;
#(
    parameter int MAX_MAP_SIDE = 256
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    tmsp_cfg_if.sink       cfg,
    output map_geom_t      geom
);

    localparam logic [SIDE_W-1:0] SIDE_TOP = SIDE_W'(MAX_MAP_SIDE);
    localparam logic [SIDE_W-1:0] PIX_TOP  = SIDE_W'(PIX_MAX);

    logic [SIDE_W-1:0] map_width_reg;
    logic [SIDE_W-1:0] map_height_reg;
    logic [SIDE_W-1:0] pix_width_reg;
    logic [SIDE_W-1:0] pix_height_reg;

    logic [SIDE_W-1:0]   w_clamped;
    logic [SIDE_W-1:0]   h_clamped;
    logic [2*SIDE_W-1:0] area;
    logic [TOTAL_W-1:0]  total;
    logic [TOTAL_W-1:0]  total_inc;
    map_geom_t           geom_next;
    map_geom_t           geom_reg;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v,
                                                      input logic [SIDE_W-1:0] top);
        logic [SIDE_W-1:0] r;
        begin
            if (v == '0)
            begin
                r = SIDE_W'(1);
            end
            else if (v > top)
            begin
                r = top;
            end
            else
            begin
                r = v;
            end
            return r;
        end
    endfunction

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= MAP_WIDTH_RESET;
            map_height_reg <= MAP_HEIGHT_RESET;
            pix_width_reg  <= PIX_WIDTH_RESET;
            pix_height_reg <= PIX_HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MAP_WIDTH:  map_width_reg  <= cfg.data;
                REG_MAP_HEIGHT: map_height_reg <= cfg.data;
                REG_PIX_WIDTH:  pix_width_reg  <= cfg.data;
                REG_PIX_HEIGHT: pix_height_reg <= cfg.data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        w_clamped       = clamp_side(map_width_reg, SIDE_TOP);
        h_clamped       = clamp_side(map_height_reg, SIDE_TOP);
        area            = {{SIDE_W{1'b0}}, w_clamped} * {{SIDE_W{1'b0}}, h_clamped};
        total           = area[TOTAL_W-1:0];
        total_inc       = total + TOTAL_W'(1);
        geom_next.width = w_clamped;
        geom_next.pix_w = clamp_side(pix_width_reg, PIX_TOP);
        geom_next.pix_h = clamp_side(pix_height_reg, PIX_TOP);
        geom_next.total = total;
        geom_next.last  = total_inc[TOTAL_W-1:1] + LAST_W'(HEADER_BYTES - 1);
    end

    always_ff @(posedge clk)
    begin
        geom_reg <= geom_next;
    end

    assign geom = geom_reg;

endmodule

`default_nettype wire

// File: src/tmsp_parse_core.sv
// Input byte register and parser state; produces at most one record per cycle.
`default_nettype none

module tmsp_parse_core
    import tmsp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    tmsp_byte_if.sink      bytes,
    input  wire map_geom_t geom,
    input  wire logic      out_free,
    output logic           res_valid,
    output record_t        res
);

    logic              in_valid_reg;
    logic [DATA_W-1:0] byte_reg;
    logic              eof_reg;

    logic [POS_W-1:0]    pos_reg,     pos_next;
    logic [HEADER_W-1:0] header_reg,  header_next;
    logic [COORD_W-1:0]  col_reg,     col_next;
    logic [COORD_W-1:0]  row_reg,     row_next;
    logic [PIXEL_W-1:0]  x_reg,       x_next;
    logic [PIXEL_W-1:0]  y_reg,       y_next;
    logic [TOTAL_W-1:0]  tiles_reg,   tiles_next;
    logic                faulted_reg, faulted_next;
    logic                phase_reg,   phase_next;

    logic                fire;
    logic                consume;
    logic                restart;
    logic                accept;
    logic [POS_W-1:0]    last_ext;
    logic [POS_W-1:0]    pos_inc;
    logic [TOTAL_W-1:0]  tiles_inc;
    logic [SIDE_W-1:0]   col_inc;
    logic [INDEX_W-1:0]  idx;
    logic [NIBBLE_W-1:0] nibble;

    assign fire        = in_valid_reg && out_free;
    assign bytes.ready = !in_valid_reg || (fire && consume);
    assign accept      = bytes.valid && bytes.ready;

    always_comb
    begin
        last_ext     = POS_W'(geom.last);
        pos_inc      = pos_reg + POS_W'(1);
        tiles_inc    = tiles_reg + TOTAL_W'(1);
        col_inc      = {1'b0, col_reg} + SIDE_W'(1);
        nibble       = phase_reg ? byte_reg[NIBBLE_W-1:0] : byte_reg[DATA_W-1:NIBBLE_W];
        idx          = '0;
        pos_next     = pos_reg;
        header_next  = header_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        tiles_next   = tiles_reg;
        faulted_next = faulted_reg;
        phase_next   = phase_reg;
        consume      = 1'b0;
        restart      = 1'b0;
        res_valid    = 1'b0;
        res          = '0;

        if (fire)
        begin
            priority if (faulted_reg)
            begin
                consume = 1'b1;
                restart = eof_reg;
            end
            else if (pos_reg > last_ext || (eof_reg && pos_reg != last_ext))
            begin
                // byte past the end, or early end of file
                res_valid    = 1'b1;
                res.kind     = KIND_ERROR;
                res.value    = VALUE_W'(pos_reg) + VALUE_W'(1);
                res.fault    = FAULT_LENGTH;
                res.run_last = 1'b1;
                consume      = 1'b1;
                restart      = eof_reg;
                faulted_next = 1'b1;
            end
            else if (pos_reg < POS_W'(HEADER_BYTES))
            begin
                header_next  = {header_reg[HEADER_W-DATA_W-1:0], byte_reg};
                idx          = header_next[INDEX_W-1:0];
                pos_next     = pos_inc;
                consume      = 1'b1;
                restart      = eof_reg;
                res.run_last = 1'b1;
                priority if (pos_reg == POS_LEVEL_END)
                begin
                    res_valid = 1'b1;
                    res.kind  = KIND_LEVEL;
                    res.value = header_next;
                end
                else if (pos_reg == POS_START_END || pos_reg == POS_FINISH_END)
                begin
                    res_valid = 1'b1;
                    res.value = VALUE_W'(idx);
                    if (TOTAL_W'(idx) >= geom.total)
                    begin
                        res.kind     = KIND_ERROR;
                        res.fault    = FAULT_INDEX;
                        faulted_next = 1'b1;
                    end
                    else if (pos_reg == POS_START_END)
                    begin
                        res.kind = KIND_START;
                    end
                    else
                    begin
                        res.kind = KIND_FINISH;
                    end
                end
                else
                begin
                    res_valid = 1'b0;
                end
            end
            else if (phase_reg || tiles_reg < geom.total)
            begin
                res_valid  = 1'b1;
                res.kind   = KIND_TILE;
                res.value  = VALUE_W'(nibble);
                res.column = col_reg;
                res.row    = row_reg;
                res.px     = x_reg;
                res.py     = y_reg;
                res.solid  = (nibble == SOLID_CODE);
                tiles_next = tiles_inc;
                if (col_inc >= geom.width)
                begin
                    col_next = '0;
                    x_next   = '0;
                    row_next = row_reg + COORD_W'(1);
                    y_next   = y_reg + PIXEL_W'(geom.pix_h);
                end
                else
                begin
                    col_next = col_inc[COORD_W-1:0];
                    x_next   = x_reg + PIXEL_W'(geom.pix_w);
                end
                if (!phase_reg && tiles_inc < geom.total)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    phase_next   = 1'b0;
                    res.run_last = 1'b1;
                    consume      = 1'b1;
                    pos_next     = pos_inc;
                    restart      = eof_reg;
                end
            end
            else
            begin
                // tiles beyond the map: no record
                consume  = 1'b1;
                pos_next = pos_inc;
                restart  = eof_reg;
            end
        end

        if (restart)
        begin
            pos_next     = '0;
            header_next  = '0;
            col_next     = '0;
            row_next     = '0;
            x_next       = '0;
            y_next       = '0;
            tiles_next   = '0;
            faulted_next = 1'b0;
            phase_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pos_reg      <= '0;
            header_reg   <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
            tiles_reg    <= '0;
            faulted_reg  <= 1'b0;
            phase_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire && consume)
            begin
                in_valid_reg <= 1'b0;
            end
            pos_reg     <= pos_next;
            header_reg  <= header_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            tiles_reg   <= tiles_next;
            faulted_reg <= faulted_next;
            phase_reg   <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= bytes.data_byte;
            eof_reg  <= bytes.end_of_file;
        end
    end

endmodule

`default_nettype wire

// File: src/tmsp_out_reg.sv
// Output record register driving the result channel.
`default_nettype none

module tmsp_out_reg
    import tmsp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      res_valid,
    input  wire record_t   res,
    output logic           out_free,
    tmsp_rec_if.source     records
);

    logic    out_valid_reg;
    record_t rec_reg;

    assign out_free = !out_valid_reg || records.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            rec_reg <= res;
        end
    end

    assign records.valid        = out_valid_reg;
    assign records.record_kind  = rec_reg.kind;
    assign records.record_value = $signed(rec_reg.value);
    assign records.fault_code   = rec_reg.fault;
    assign records.tile_column  = rec_reg.column;
    assign records.tile_row     = rec_reg.row;
    assign records.pixel_x      = rec_reg.px;
    assign records.pixel_y      = rec_reg.py;
    assign records.is_solid     = rec_reg.solid;
    assign records.run_last     = rec_reg.run_last;

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the tile-map stream parser; checks records in order.
module testbench
    import tmsp_pkg::*;
;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_BYTES  = 950;
    localparam int CALM_FROM     = 830;
    localparam int MAX_REPORTS   = 40;
    localparam int MAP_SIDE_MAX  = 256;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = CFG_INDEX_W'(8'hff);

    class tile_map_scoreboard;
        logic [SIDE_W-1:0]   map_w, map_h, pix_w, pix_h;
        logic [POS_W-1:0]    byte_pos;
        logic [HEADER_W-1:0] header;
        logic [COORD_W-1:0]  col, row;
        logic [PIXEL_W-1:0]  x_acc, y_acc;
        logic [TOTAL_W-1:0]  tile_count;
        bit                  faulted;
        record_t             expected_q[$];
        int                  errors;

        function new();
            map_w  = MAP_WIDTH_RESET;
            map_h  = MAP_HEIGHT_RESET;
            pix_w  = PIX_WIDTH_RESET;
            pix_h  = PIX_HEIGHT_RESET;
            errors = 0;
            restart();
        endfunction

        function void restart();
            byte_pos   = '0;
            header     = '0;
            col        = '0;
            row        = '0;
            x_acc      = '0;
            y_acc      = '0;
            tile_count = '0;
            faulted    = 1'b0;
        endfunction

        function int unsigned clamp_side(logic [SIDE_W-1:0] v, int unsigned top);
            if (v == 0)
                return 1;
            if (v > top)
                return top;
            return 32'(v);
        endfunction

        function int unsigned tile_total();
            return clamp_side(map_w, MAP_SIDE_MAX) * clamp_side(map_h, MAP_SIDE_MAX);
        endfunction

        function int unsigned file_bytes();
            return HEADER_BYTES + (tile_total() + 1) / 2;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [SIDE_W-1:0] val);
            case (idx)
                REG_MAP_WIDTH:  map_w = val;
                REG_MAP_HEIGHT: map_h = val;
                REG_PIX_WIDTH:  pix_w = val;
                REG_PIX_HEIGHT: pix_h = val;
                default: ;
            endcase
        endfunction

        function void push(record_kind_t kind, logic [VALUE_W-1:0] value, fault_code_t fault);
            record_t r;
            r       = '0;
            r.kind  = kind;
            r.value = value;
            r.fault = fault;
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void push_tile(logic [NIBBLE_W-1:0] code, int unsigned w, int unsigned pw,
                                int unsigned ph);
            record_t r;
            r        = '0;
            r.kind   = KIND_TILE;
            r.value  = VALUE_W'(code);
            r.column = col;
            r.row    = row;
            r.px     = x_acc;
            r.py     = y_acc;
            r.solid  = (code == SOLID_CODE);
            expected_q.insert(expected_q.size(), r);
            tile_count = tile_count + TOTAL_W'(1);
            if (int'(col) + 1 >= w)
            begin
                col   = '0;
                x_acc = '0;
                row   = row + COORD_W'(1);
                y_acc = y_acc + PIXEL_W'(ph);
            end
            else
            begin
                col   = col + COORD_W'(1);
                x_acc = x_acc + PIXEL_W'(pw);
            end
        endfunction

        function void mark_run_last(int n_before);
            record_t r;
            if (expected_q.size() > n_before)
            begin
                r = expected_q[expected_q.size() - 1];
                r.run_last = 1'b1;
                expected_q[expected_q.size() - 1] = r;
            end
        endfunction

        function void note_byte(logic [DATA_W-1:0] b, logic eof);
            int unsigned w, h, pw, ph, total, last, pos;
            int n_before;
            logic [INDEX_W-1:0] idx;
            n_before = expected_q.size();
            w     = clamp_side(map_w, MAP_SIDE_MAX);
            h     = clamp_side(map_h, MAP_SIDE_MAX);
            pw    = clamp_side(pix_w, PIX_MAX);
            ph    = clamp_side(pix_h, PIX_MAX);
            total = w * h;
            last  = HEADER_BYTES + (total + 1) / 2 - 1;
            pos   = 32'(byte_pos);
            if (faulted)
            begin
                if (eof)
                    restart();
                return;
            end
            if (pos > last || (eof && pos != last))
            begin
                push(KIND_ERROR, pos + 1, FAULT_LENGTH);
                if (eof)
                    restart();
                else
                    faulted = 1'b1;
                mark_run_last(n_before);
                return;
            end
            if (pos < HEADER_BYTES)
            begin
                header = {header[HEADER_W-9:0], b};
                if (pos == POS_LEVEL_END)
                    push(KIND_LEVEL, header, FAULT_NONE);
                else if (pos == POS_START_END || pos == POS_FINISH_END)
                begin
                    idx = header[INDEX_W-1:0];
                    if (idx >= total)
                    begin
                        push(KIND_ERROR, VALUE_W'(idx), FAULT_INDEX);
                        faulted = 1'b1;
                    end
                    else
                        push(record_kind_t'(pos == POS_START_END ? KIND_START : KIND_FINISH),
                             VALUE_W'(idx), FAULT_NONE);
                end
            end
            else
            begin
                if (tile_count < total)
                    push_tile(b[7:4], w, pw, ph);
                if (tile_count < total)
                    push_tile(b[3:0], w, pw, ph);
            end
            byte_pos = POS_W'(pos + 1);
            if (eof)
                restart();
            mark_run_last(n_before);
        endfunction

        function string fmt(record_t r);
            return $sformatf({"kind=%0d value=%h fault=%0d col=%0d row=%0d x=%0d y=%0d",
                              " solid=%b last=%b"},
                             r.kind, r.value, r.fault, r.column, r.row, r.px, r.py, r.solid,
                             r.run_last);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch: %s", msg);
        endtask

        task check_record(record_t got);
            record_t want;
            string bad;
            if (expected_q.size() == 0)
            begin
                report({"record with none pending: ", fmt(got)});
                return;
            end
            want = expected_q.pop_front();
            bad  = "";
            if (got.kind !== want.kind)         bad = {bad, " kind"};
            if (got.value !== want.value)       bad = {bad, " value"};
            if (got.fault !== want.fault)       bad = {bad, " fault"};
            if (got.column !== want.column)     bad = {bad, " column"};
            if (got.row !== want.row)           bad = {bad, " row"};
            if (got.px !== want.px)             bad = {bad, " pixel_x"};
            if (got.py !== want.py)             bad = {bad, " pixel_y"};
            if (got.solid !== want.solid)       bad = {bad, " solid"};
            if (got.run_last !== want.run_last) bad = {bad, " run_last"};
            if (bad != "")
                report({"field", bad, ": got ", fmt(got), " / want ", fmt(want)});
        endtask
    endclass

    logic clk;
    logic rst_n;

    tmsp_byte_if byte_ch ();
    tmsp_rec_if  rec_ch ();
    tmsp_cfg_if  cfg_ch ();

    tile_map_stream_parser #(
        .MAX_MAP_SIDE (MAP_SIDE_MAX)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (byte_ch),
        .records (rec_ch),
        .cfg     (cfg_ch)
    );

    tile_map_scoreboard sb;
    int                 bytes_sent;
    bit                 calm;
    int unsigned        cycles;
    int                 ready_burst;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (ready_burst > 0)
            ready_burst--;
        else if (!calm && $urandom_range(0, 3) == 0)
        begin
            rec_ch.ready = 1'b0;
            ready_burst  = $urandom_range(0, 8);
        end
        else
        begin
            rec_ch.ready = 1'b1;
            ready_burst  = $urandom_range(0, 12);
        end
    end

    always @(posedge clk)
    begin
        record_t got;
        if (rst_n && rec_ch.valid && rec_ch.ready)
        begin
            got.kind     = record_kind_t'(rec_ch.record_kind);
            got.value    = rec_ch.record_value;
            got.fault    = fault_code_t'(rec_ch.fault_code);
            got.column   = rec_ch.tile_column;
            got.row      = rec_ch.tile_row;
            got.px       = rec_ch.pixel_x;
            got.py       = rec_ch.pixel_y;
            got.solid    = rec_ch.is_solid;
            got.run_last = rec_ch.run_last;
            sb.check_record(got);
        end
    end

    task automatic send_byte(input logic [DATA_W-1:0] b, input logic eof);
        @(negedge clk);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            byte_ch.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        byte_ch.valid       = 1'b1;
        byte_ch.data_byte   = b;
        byte_ch.end_of_file = eof;
        do @(posedge clk); while (!byte_ch.ready);
        sb.note_byte(b, eof);
        bytes_sent++;
    endtask

    task automatic wait_records_out();
        @(negedge clk);
        byte_ch.valid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [SIDE_W-1:0] val);
        @(negedge clk);
        byte_ch.valid = 1'b0;
        cfg_ch.valid  = 1'b1;
        cfg_ch.index  = idx;
        cfg_ch.data   = val;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_geometry(input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h,
                                input logic [SIDE_W-1:0] pw, input logic [SIDE_W-1:0] ph);
        wait_records_out();
        write_reg(REG_MAP_WIDTH, w);
        write_reg(REG_MAP_HEIGHT, h);
        write_reg(REG_PIX_WIDTH, pw);
        write_reg(REG_PIX_HEIGHT, ph);
    endtask

    // header bytes big-endian, then random tile bytes
    task automatic send_stream(input logic [31:0] level, input logic [15:0] start_idx,
                               input logic [15:0] finish_idx, input int count,
                               input bit eof_last);
        logic [63:0]       head;
        logic [DATA_W-1:0] b;
        head = {level, start_idx, finish_idx};
        for (int i = 0; i < count; i++)
        begin
            if (i < HEADER_BYTES)
                b = head[63 - 8*i -: 8];
            else
                b = ($urandom_range(0, 3) == 0) ? 8'h11 : DATA_W'($urandom);
            send_byte(b, eof_last && i == count - 1);
        end
    endtask

    function automatic logic [31:0] random_level();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_file();
        int unsigned total, len;
        int pick, n;
        logic [15:0] s, f;
        logic [31:0] level;
        total = sb.tile_total();
        len   = sb.file_bytes();
        level = random_level();
        s     = 16'($urandom_range(0, total - 1));
        f     = 16'($urandom_range(0, total - 1));
        pick  = $urandom_range(0, 99);
        if (pick < 65 && len <= 200)
            send_stream(level, s, f, len, 1'b1);
        else if (pick < 80)
            send_stream(level, s, f, $urandom_range(1, (len - 1 < 24) ? len - 1 : 24), 1'b1);
        else if (pick < 88 && len <= 200)
            send_stream(level, s, f, len + $urandom_range(1, 3), 1'b1);
        else if (pick < 95 && total < 65536)
        begin
            if ($urandom_range(0, 1) == 0)
                s = 16'($urandom_range(total, 65535));
            else
                f = 16'($urandom_range(total, 65535));
            send_stream(level, s, f, $urandom_range(7, (len < 30) ? len : 30), 1'b1);
        end
        else
        begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                send_byte(DATA_W'($urandom), i == n - 1 || $urandom_range(0, 5) == 0);
        end
    endtask

    initial
    begin
        int phase_no, phase_end, tail, len;
        logic [SIDE_W-1:0] w, h, pw, ph;
        bit mid_file;

        sb                  = new();
        bytes_sent          = 0;
        calm                = 1'b0;
        cycles              = 0;
        ready_burst         = 0;
        rst_n               = 1'b0;
        byte_ch.valid       = 1'b0;
        byte_ch.data_byte   = '0;
        byte_ch.end_of_file = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        rec_ch.ready        = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset geometry: level record, then early end of file
        send_stream(32'hff00_807f, 16'h0, 16'h0, 5, 1'b1);
        wait_records_out();
        write_reg(REG_SPARE, 9'h1ff);
        // one column, three rows: row wrap, solid tile, pad nibble dropped
        set_geometry(9'd1, 9'd3, 9'd255, 9'd256);
        send_stream(32'h0123_4567, 16'h0002, 16'h0000, HEADER_BYTES, 1'b0);
        send_byte(8'hf1, 1'b0);
        send_byte(8'h0e, 1'b1);
        // start index out of bounds, silent until end of file
        send_stream(32'h0, 16'h0003, 16'h0000, 6, 1'b0);
        send_byte(8'h55, 1'b1);
        // end of file on the first byte
        send_byte(8'hff, 1'b1);

        phase_no = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            if (bytes_sent >= CALM_FROM)
                calm = 1'b1;
            case (phase_no)
                0:       begin w = 9'd511; h = 9'd1;   pw = 9'd0;   ph = 9'd511; end
                1:       begin w = 9'd1;   h = 9'd256; pw = 9'd256; ph = 9'd1;   end
                2:       begin w = 9'd256; h = 9'd256; pw = 9'd1;   ph = 9'd255; end
                3:       begin w = 9'd0;   h = 9'd0;   pw = 9'd511; ph = 9'd0;   end
                default:
                begin
                    w  = ($urandom_range(0, 9) == 0) ? SIDE_W'($urandom)
                                                     : SIDE_W'($urandom_range(1, 12));
                    h  = ($urandom_range(0, 9) == 0) ? SIDE_W'($urandom_range(0, 40))
                                                     : SIDE_W'($urandom_range(1, 12));
                    pw = SIDE_W'($urandom_range(0, 511));
                    ph = SIDE_W'($urandom_range(0, 511));
                end
            endcase
            // leave the parser mid-file across the register change
            mid_file = ($urandom_range(0, 2) == 0);
            if (mid_file)
            begin
                len = sb.file_bytes();
                send_stream(random_level(), 16'h0, 16'h0,
                            $urandom_range(1, (len - 1 < 20) ? len - 1 : 20), 1'b0);
            end
            set_geometry(w, h, pw, ph);
            if (mid_file)
            begin
                tail = $urandom_range(1, 6);
                for (int i = 0; i < tail; i++)
                    send_byte(DATA_W'($urandom), i == tail - 1);
            end
            phase_end = bytes_sent + $urandom_range(60, 140);
            while (bytes_sent < phase_end && bytes_sent < RANDOM_BYTES)
            begin
                if (bytes_sent >= CALM_FROM)
                    calm = 1'b1;
                send_file();
                if ($urandom_range(0, 9) == 0)
                    wait_records_out();
            end
            phase_no++;
        end

        wait_records_out();
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
